// ===== src/flrm_pkg.sv =====
// Shared types and constants for the flow ratio limit monitor.
package flrm_pkg;

    localparam int RATIO_WIDTH     = 16;
    localparam int FILTER_WIDTH    = 8;
    localparam int CFG_INDEX_WIDTH = 3;
    localparam int CFG_DATA_WIDTH  = 16;
    localparam int AC_MIN_DELTA    = 5;

    localparam logic [RATIO_WIDTH-1:0]  MIN_RATIO_RESET   = 16'd1536;
    localparam logic [RATIO_WIDTH-1:0]  MAX_RATIO_RESET   = 16'd3328;
    localparam logic [FILTER_WIDTH-1:0] LOW_FILTER_RESET  = 8'd10;
    localparam logic [FILTER_WIDTH-1:0] HIGH_FILTER_RESET = 8'd10;

    typedef enum logic [1:0] {
        CMD_SAMPLE      = 2'd0,
        CMD_STATE       = 2'd1,
        CMD_CYCLE_START = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        CLASS_ACTIVATE   = 2'd0,
        CLASS_DEACTIVATE = 2'd1,
        CLASS_NO_CHANGE  = 2'd2
    } t_class;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        CFG_MIN_RATIO   = 3'd0,
        CFG_MAX_RATIO   = 3'd1,
        CFG_LOW_FILTER  = 3'd2,
        CFG_HIGH_FILTER = 3'd3,
        CFG_MON_ENABLE  = 3'd4
    } t_cfg_index;

    typedef struct packed {
        logic below;
        logic above;
    } t_ratio_flags;

    typedef struct packed {
        logic step;
        logic clear;
        logic fail;
    } t_cnt_ctrl;

endpackage

// ===== src/flrm_in_if.sv =====
// Input channel: one sample or command word with valid/ready handshake.
interface flrm_in_if #(
    parameter int VOLUME_WIDTH = 20
);
    logic                    valid;
    logic                    ready;
    logic [1:0]              cmd;
    logic                    draw_phase;
    logic [1:0]              state_class;
    logic [VOLUME_WIDTH-1:0] delta_ac;
    logic [VOLUME_WIDTH-1:0] delta_inlet;
    logic [VOLUME_WIDTH-1:0] delta_return;

    modport source (
        output valid, cmd, draw_phase, state_class, delta_ac, delta_inlet, delta_return,
        input  ready
    );
    modport sink (
        input  valid, cmd, draw_phase, state_class, delta_ac, delta_inlet, delta_return,
        output ready
    );
endinterface

// ===== src/flrm_res_if.sv =====
// Result channel: one status word per input word with valid/ready handshake.
interface flrm_res_if #(
    parameter int COUNT_WIDTH = 8
);
    logic                   valid;
    logic                   ready;
    logic                   low_alarm;
    logic                   high_alarm;
    logic                   dump_request;
    logic [COUNT_WIDTH-1:0] low_count_out;
    logic [COUNT_WIDTH-1:0] high_count_out;
    logic                   active_out;

    modport source (
        output valid, low_alarm, high_alarm, dump_request, low_count_out, high_count_out,
               active_out,
        input  ready
    );
    modport sink (
        input  valid, low_alarm, high_alarm, dump_request, low_count_out, high_count_out,
               active_out,
        output ready
    );
endinterface

// ===== src/flow_ratio_limit_monitor_top.sv =====
// Top level: input register, ratio check, limit counters and result register.
// Flow: a word accepted into the input register moves into the result register once
// that register is empty or is being read out; a stalled receiver holds it back.
// Throughput: one word per cycle while the receiver takes results; both multiplies and
// counter updates finish in the single stage between the input register and the result register.
// Reset (synchronous, active low): counters and active clear, dump request is armed,
// configuration returns to its defaults and both pipeline stages empty.
module flow_ratio_limit_monitor_top #(
    parameter int VOLUME_WIDTH = 20,
    parameter int COUNT_WIDTH  = 8
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    flrm_in_if.sink                              i_in,
    flrm_res_if.source                           o_res,
    input  logic                                 i_cfg_we,
    input  logic [flrm_pkg::CFG_INDEX_WIDTH-1:0] i_cfg_index,
    input  logic [flrm_pkg::CFG_DATA_WIDTH-1:0]  i_cfg_data
);
    // Configuration registers
    logic [flrm_pkg::RATIO_WIDTH-1:0]  r_min_ratio;
    logic [flrm_pkg::RATIO_WIDTH-1:0]  r_max_ratio;
    logic [flrm_pkg::FILTER_WIDTH-1:0] r_low_filter;
    logic [flrm_pkg::FILTER_WIDTH-1:0] r_high_filter;
    logic                              r_mon_enable;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_ratio   <= flrm_pkg::MIN_RATIO_RESET;
            r_max_ratio   <= flrm_pkg::MAX_RATIO_RESET;
            r_low_filter  <= flrm_pkg::LOW_FILTER_RESET;
            r_high_filter <= flrm_pkg::HIGH_FILTER_RESET;
            r_mon_enable  <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                flrm_pkg::CFG_MIN_RATIO:   r_min_ratio   <= i_cfg_data;
                flrm_pkg::CFG_MAX_RATIO:   r_max_ratio   <= i_cfg_data;
                flrm_pkg::CFG_LOW_FILTER:  r_low_filter  <= i_cfg_data[flrm_pkg::FILTER_WIDTH-1:0];
                flrm_pkg::CFG_HIGH_FILTER: r_high_filter <= i_cfg_data[flrm_pkg::FILTER_WIDTH-1:0];
                flrm_pkg::CFG_MON_ENABLE:  r_mon_enable  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Input register stage
    logic                    r_s1_valid;
    logic [1:0]              r_cmd;
    logic                    r_draw;
    logic [1:0]              r_class;
    logic [VOLUME_WIDTH-1:0] r_ac;
    logic [VOLUME_WIDTH-1:0] r_inlet;
    logic [VOLUME_WIDTH-1:0] r_return;

    logic r_out_valid;
    logic s1_advance;
    logic in_take;

    assign s1_advance = r_s1_valid && (!r_out_valid || o_res.ready);
    assign i_in.ready = !r_s1_valid || s1_advance;
    assign in_take    = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_s1_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_cmd    <= i_in.cmd;
            r_draw   <= i_in.draw_phase;
            r_class  <= i_in.state_class;
            r_ac     <= i_in.delta_ac;
            r_inlet  <= i_in.delta_inlet;
            r_return <= i_in.delta_return;
        end
    end

    // Processing of the word held in the input register
    flrm_pkg::t_ratio_flags flags;
    flrm_pkg::t_cnt_ctrl    lo_ctrl;
    flrm_pkg::t_cnt_ctrl    hi_ctrl;
    logic [COUNT_WIDTH-1:0] lo_count_next;
    logic [COUNT_WIDTH-1:0] hi_count_next;
    logic                   lo_alarm;
    logic                   hi_alarm;
    logic                   sample_check;
    logic                   cycle_clear;
    logic                   r_active;
    logic                   n_active;
    logic                   r_dump_pending;
    logic                   dump;

    flrm_ratio_check #(
        .VOLUME_WIDTH(VOLUME_WIDTH)
    ) u_ratio (
        .i_delta_ac    (r_ac),
        .i_delta_inlet (r_inlet),
        .i_delta_return(r_return),
        .i_min_ratio   (r_min_ratio),
        .i_max_ratio   (r_max_ratio),
        .o_flags       (flags)
    );

    always_comb begin
        sample_check = 1'b0;
        cycle_clear  = 1'b0;
        n_active     = r_active;
        unique case (r_cmd)
            flrm_pkg::CMD_SAMPLE: begin
                sample_check = r_active && r_mon_enable && r_draw &&
                               (r_ac > VOLUME_WIDTH'(flrm_pkg::AC_MIN_DELTA));
            end
            flrm_pkg::CMD_STATE: begin
                if (r_class == flrm_pkg::CLASS_ACTIVATE) begin
                    n_active = 1'b1;
                end else if (r_class == flrm_pkg::CLASS_DEACTIVATE) begin
                    n_active = 1'b0;
                end
            end
            flrm_pkg::CMD_CYCLE_START: begin
                cycle_clear = r_draw;
            end
            default: ;
        endcase
    end

    assign lo_ctrl.step  = s1_advance && sample_check;
    assign lo_ctrl.clear = s1_advance && cycle_clear;
    assign lo_ctrl.fail  = flags.below;
    assign hi_ctrl.step  = s1_advance && sample_check;
    assign hi_ctrl.clear = s1_advance && cycle_clear;
    assign hi_ctrl.fail  = flags.above;

    flrm_counter #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_low_cnt (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (lo_ctrl),
        .i_filter    (r_low_filter),
        .o_count_next(lo_count_next),
        .o_alarm     (lo_alarm)
    );

    flrm_counter #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_high_cnt (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (hi_ctrl),
        .i_filter    (r_high_filter),
        .o_count_next(hi_count_next),
        .o_alarm     (hi_alarm)
    );

    assign dump = (lo_alarm || hi_alarm) && r_dump_pending;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active       <= 1'b0;
            r_dump_pending <= 1'b1;
        end else if (s1_advance) begin
            r_active <= n_active;
            if (dump) begin
                r_dump_pending <= 1'b0;
            end
        end
    end

    // Result register
    logic                   r_res_low_alarm;
    logic                   r_res_high_alarm;
    logic                   r_res_dump;
    logic [COUNT_WIDTH-1:0] r_res_low_count;
    logic [COUNT_WIDTH-1:0] r_res_high_count;
    logic                   r_res_active;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_advance) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_advance) begin
            r_res_low_alarm  <= lo_alarm;
            r_res_high_alarm <= hi_alarm;
            r_res_dump       <= dump;
            r_res_low_count  <= lo_count_next;
            r_res_high_count <= hi_count_next;
            r_res_active     <= n_active;
        end
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.low_alarm      = r_res_low_alarm;
    assign o_res.high_alarm     = r_res_high_alarm;
    assign o_res.dump_request   = r_res_dump;
    assign o_res.low_count_out  = r_res_low_count;
    assign o_res.high_count_out = r_res_high_count;
    assign o_res.active_out     = r_res_active;
endmodule

// ===== src/flrm_ratio_check.sv =====
// Cross-multiplied ratio test of (inlet - return) / ac against both limits.
module flrm_ratio_check #(
    parameter int VOLUME_WIDTH = 20
) (
    input  logic [VOLUME_WIDTH-1:0]             i_delta_ac,
    input  logic [VOLUME_WIDTH-1:0]             i_delta_inlet,
    input  logic [VOLUME_WIDTH-1:0]             i_delta_return,
    input  logic [flrm_pkg::RATIO_WIDTH-1:0]    i_min_ratio,
    input  logic [flrm_pkg::RATIO_WIDTH-1:0]    i_max_ratio,
    output flrm_pkg::t_ratio_flags              o_flags
);
    localparam int PROD_WIDTH = VOLUME_WIDTH + flrm_pkg::RATIO_WIDTH;

    logic [VOLUME_WIDTH:0]   diff;
    logic                    diff_neg;
    logic [PROD_WIDTH-1:0]   scaled_diff;
    logic [PROD_WIDTH-1:0]   lo_lim;
    logic [PROD_WIDTH-1:0]   hi_lim;

    assign diff     = {1'b0, i_delta_inlet} - {1'b0, i_delta_return};
    assign diff_neg = diff[VOLUME_WIDTH];

    // Scaling by 256 matches the Q8.8 limits; the top 8 bits stay zero.
    assign scaled_diff = {8'd0, diff[VOLUME_WIDTH-1:0], 8'd0};
    assign lo_lim      = PROD_WIDTH'(i_min_ratio) * PROD_WIDTH'(i_delta_ac);
    assign hi_lim      = PROD_WIDTH'(i_max_ratio) * PROD_WIDTH'(i_delta_ac);

    // A negative difference sits below every limit and above none.
    assign o_flags.below = diff_neg || (scaled_diff < lo_lim);
    assign o_flags.above = !diff_neg && (scaled_diff > hi_lim);
endmodule

// ===== src/flrm_counter.sv =====
// Saturating up/down leaky counter with filter compare for one limit.
module flrm_counter #(
    parameter int COUNT_WIDTH = 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  flrm_pkg::t_cnt_ctrl               i_ctrl,
    input  logic [flrm_pkg::FILTER_WIDTH-1:0] i_filter,
    output logic [COUNT_WIDTH-1:0]            o_count_next,
    output logic                              o_alarm
);
    localparam int CMP_WIDTH = (COUNT_WIDTH > flrm_pkg::FILTER_WIDTH) ?
                               COUNT_WIDTH : flrm_pkg::FILTER_WIDTH;
    localparam logic [COUNT_WIDTH-1:0] COUNT_TOP = '1;

    logic [COUNT_WIDTH-1:0] r_count;
    logic [COUNT_WIDTH-1:0] n_count;

    always_comb begin
        n_count = r_count;
        if (i_ctrl.clear) begin
            n_count = '0;
        end else if (i_ctrl.step) begin
            if (i_ctrl.fail) begin
                if (r_count != COUNT_TOP) begin
                    n_count = r_count + COUNT_WIDTH'(1);
                end
            end else if (r_count != '0) begin
                n_count = r_count - COUNT_WIDTH'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    assign o_count_next = n_count;
    assign o_alarm = i_ctrl.step && !i_ctrl.clear && i_ctrl.fail &&
                     (CMP_WIDTH'(n_count) > CMP_WIDTH'(i_filter));
endmodule

// ===== src/flrm_checker.sv =====
// Port-level checks on the result channel of the monitor, bound to the top level.
module flrm_checker #(
    parameter int COUNT_WIDTH = 8
) (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_res_valid,
    input logic                   i_res_ready,
    input logic                   i_low_alarm,
    input logic                   i_high_alarm,
    input logic                   i_dump_request,
    input logic [COUNT_WIDTH-1:0] i_low_count,
    input logic                   i_active
);
    logic r_dump_seen;

    // Remembers that a dump request word has already been delivered.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dump_seen <= 1'b0;
        end else if (i_res_valid && i_res_ready && i_dump_request) begin
            r_dump_seen <= 1'b1;
        end
    end

    a_dump_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_dump_seen && i_res_valid) |-> !i_dump_request)
        else $error("second dump request after reset");

    a_dump_needs_alarm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && i_dump_request) |-> (i_low_alarm || i_high_alarm))
        else $error("dump request without an alarm");

    a_alarm_needs_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && (i_low_alarm || i_high_alarm)) |-> i_active)
        else $error("alarm while monitoring inactive");

    a_low_alarm_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && i_low_alarm) |-> (i_low_count != '0))
        else $error("low alarm with zero low count");

    a_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && !i_res_ready) |=> i_res_valid)
        else $error("result word dropped while stalled");
endmodule

bind flow_ratio_limit_monitor_top flrm_checker #(
    .COUNT_WIDTH(COUNT_WIDTH)
) u_flrm_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_res_valid   (o_res.valid),
    .i_res_ready   (o_res.ready),
    .i_low_alarm   (o_res.low_alarm),
    .i_high_alarm  (o_res.high_alarm),
    .i_dump_request(o_res.dump_request),
    .i_low_count   (o_res.low_count_out),
    .i_active      (o_res.active_out)
);

// ===== sim/flrm_status_checker.sv =====
// Status checker: predicts each result word from accepted input words and compares.
module flrm_status_checker #(
    parameter int VOLUME_WIDTH = 20,
    parameter int COUNT_WIDTH  = 8
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    flrm_in_if                                   i_in,
    flrm_res_if                                  i_res,
    input  logic                                 i_cfg_we,
    input  logic [flrm_pkg::CFG_INDEX_WIDTH-1:0] i_cfg_index,
    input  logic [flrm_pkg::CFG_DATA_WIDTH-1:0]  i_cfg_data,
    output int                                   o_fail_count,
    output int                                   o_words_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic                   low_alarm;
        logic                   high_alarm;
        logic                   dump_request;
        logic [COUNT_WIDTH-1:0] low_count;
        logic [COUNT_WIDTH-1:0] high_count;
        logic                   active;
    } t_status;

    t_status expected_q[$];
    int      fail_count = 0;

    logic [flrm_pkg::RATIO_WIDTH-1:0]  min_ratio;
    logic [flrm_pkg::RATIO_WIDTH-1:0]  max_ratio;
    logic [flrm_pkg::FILTER_WIDTH-1:0] low_filter;
    logic [flrm_pkg::FILTER_WIDTH-1:0] high_filter;
    logic                              mon_enable;
    logic                              mon_active;
    logic [COUNT_WIDTH-1:0]            low_count;
    logic [COUNT_WIDTH-1:0]            high_count;
    logic                              dump_armed;

    // Leaky counter step; the return value tells whether this step raises an alarm.
    function automatic logic step_limit_counter(
        inout logic [COUNT_WIDTH-1:0] cnt,
        input logic fail,
        input logic [flrm_pkg::FILTER_WIDTH-1:0] filter);
        if (fail) begin
            if (cnt != {COUNT_WIDTH{1'b1}})
                cnt = cnt + 1'b1;
            return cnt > filter;
        end
        if (cnt != '0)
            cnt = cnt - 1'b1;
        return 1'b0;
    endfunction

    function automatic t_status predict_status(input logic [1:0] cmd,
                                               input logic draw,
                                               input logic [1:0] cls,
                                               input logic [VOLUME_WIDTH-1:0] ac,
                                               input logic [VOLUME_WIDTH-1:0] inlet,
                                               input logic [VOLUME_WIDTH-1:0] ret);
        t_status s;
        longint  diff;
        longint  low_lim;
        longint  high_lim;
        s.low_alarm    = 1'b0;
        s.high_alarm   = 1'b0;
        s.dump_request = 1'b0;
        if (cmd == flrm_pkg::CMD_SAMPLE) begin
            if (mon_active && mon_enable && draw && ac > flrm_pkg::AC_MIN_DELTA) begin
                // Cross-multiplied ratio test; a negative difference is below any limit.
                diff     = (longint'(inlet) - longint'(ret)) * 256;
                low_lim  = longint'(min_ratio) * longint'(ac);
                high_lim = longint'(max_ratio) * longint'(ac);
                s.low_alarm  = step_limit_counter(low_count, diff < low_lim, low_filter);
                s.high_alarm = step_limit_counter(high_count, diff > high_lim, high_filter);
                if ((s.low_alarm || s.high_alarm) && dump_armed) begin
                    dump_armed     = 1'b0;
                    s.dump_request = 1'b1;
                end
            end
        end else if (cmd == flrm_pkg::CMD_STATE) begin
            if (cls == flrm_pkg::CLASS_ACTIVATE)
                mon_active = 1'b1;
            else if (cls == flrm_pkg::CLASS_DEACTIVATE)
                mon_active = 1'b0;
        end else if (cmd == flrm_pkg::CMD_CYCLE_START) begin
            if (draw) begin
                low_count  = '0;
                high_count = '0;
            end
        end
        s.low_count  = low_count;
        s.high_count = high_count;
        s.active     = mon_active;
        return s;
    endfunction

    task automatic check_field(input string name, input logic [31:0] exp_val,
                               input logic [31:0] act_val);
        if (act_val !== exp_val) begin
            $error("%s: expected %0d, got %0d", name, exp_val, act_val);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_status exp_s;
        if (!i_rst_n) begin
            min_ratio   = flrm_pkg::MIN_RATIO_RESET;
            max_ratio   = flrm_pkg::MAX_RATIO_RESET;
            low_filter  = flrm_pkg::LOW_FILTER_RESET;
            high_filter = flrm_pkg::HIGH_FILTER_RESET;
            mon_enable  = 1'b0;
            mon_active  = 1'b0;
            low_count   = '0;
            high_count  = '0;
            dump_armed  = 1'b1;
            expected_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    flrm_pkg::CFG_MIN_RATIO:
                        min_ratio = i_cfg_data[flrm_pkg::RATIO_WIDTH-1:0];
                    flrm_pkg::CFG_MAX_RATIO:
                        max_ratio = i_cfg_data[flrm_pkg::RATIO_WIDTH-1:0];
                    flrm_pkg::CFG_LOW_FILTER:
                        low_filter = i_cfg_data[flrm_pkg::FILTER_WIDTH-1:0];
                    flrm_pkg::CFG_HIGH_FILTER:
                        high_filter = i_cfg_data[flrm_pkg::FILTER_WIDTH-1:0];
                    flrm_pkg::CFG_MON_ENABLE:
                        mon_enable = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_in.valid && i_in.ready)
                expected_q.push_back(predict_status(i_in.cmd, i_in.draw_phase,
                                                    i_in.state_class, i_in.delta_ac,
                                                    i_in.delta_inlet, i_in.delta_return));
            if (i_res.valid && i_res.ready) begin
                if (expected_q.size() == 0) begin
                    $error("result word with no expected status waiting");
                    fail_count++;
                end else begin
                    exp_s = expected_q.pop_front();
                    check_field("low_alarm", exp_s.low_alarm, i_res.low_alarm);
                    check_field("high_alarm", exp_s.high_alarm, i_res.high_alarm);
                    check_field("dump_request", exp_s.dump_request, i_res.dump_request);
                    check_field("low_count_out", exp_s.low_count, i_res.low_count_out);
                    check_field("high_count_out", exp_s.high_count, i_res.high_count_out);
                    check_field("active_out", exp_s.active, i_res.active_out);
                end
            end
        end
        o_words_pending <= expected_q.size();
        o_fail_count    <= fail_count;
    end

endmodule

// ===== sim/flow_ratio_limit_monitor_top_test.sv =====
// Testbench top: clock, reset, stimulus and configuration for the flow ratio monitor.
module flow_ratio_limit_monitor_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int         VOLUME_WIDTH     = 20;
    localparam int         COUNT_WIDTH      = 8;
    localparam int         RATIO_WIDTH      = flrm_pkg::RATIO_WIDTH;
    localparam int         FILTER_WIDTH     = flrm_pkg::FILTER_WIDTH;
    localparam int         CFG_INDEX_WIDTH  = flrm_pkg::CFG_INDEX_WIDTH;
    localparam int         CFG_DATA_WIDTH   = flrm_pkg::CFG_DATA_WIDTH;
    localparam logic [1:0] CMD_RESERVED     = 2'd3;
    localparam logic [1:0] CLASS_RESERVED   = 2'd3;
    localparam longint     VOL_TOP          = (longint'(1) << VOLUME_WIDTH) - 1;
    localparam int         RANDOM_PHASES    = 8;
    localparam int         PHASE_WORDS      = 170;
    localparam int         SATURATE_PHASE   = 5;
    localparam int         SATURATE_WORDS   = 340;
    localparam int         HOLD_PHASE       = 2;
    localparam int         LONG_HOLD_CYCLES = 300;
    localparam int         CYCLE_LIMIT      = 600_000;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       cfg_we;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index;
    logic [CFG_DATA_WIDTH-1:0]  cfg_data;
    int                         fail_count;
    int                         words_pending;
    int                         cycle_count = 0;
    bit                         hold_request = 1'b0;
    bit                         hold_active = 1'b0;

    // Current limits, used only to aim sample ratios near them.
    logic [RATIO_WIDTH-1:0] cur_min = flrm_pkg::MIN_RATIO_RESET;
    logic [RATIO_WIDTH-1:0] cur_max = flrm_pkg::MAX_RATIO_RESET;

    flrm_in_if  #(.VOLUME_WIDTH(VOLUME_WIDTH)) in_ch ();
    flrm_res_if #(.COUNT_WIDTH(COUNT_WIDTH))   res_ch ();

    flow_ratio_limit_monitor_top #(
        .VOLUME_WIDTH(VOLUME_WIDTH),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in       (in_ch),
        .o_res      (res_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_index(cfg_index),
        .i_cfg_data (cfg_data)
    );

    flrm_status_checker #(
        .VOLUME_WIDTH(VOLUME_WIDTH),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) status_check (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in           (in_ch),
        .i_res          (res_ch),
        .i_cfg_we       (cfg_we),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .o_fail_count   (fail_count),
        .o_words_pending(words_pending)
    );

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Receiver: segments of full speed, random ready, mostly ready and stalls, plus one
    // long hold-off on request.
    initial begin
        int seg_kind;
        int seg_len;
        res_ch.ready <= 1'b0;
        @(posedge clk);
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                hold_active  = 1'b1;
                res_ch.ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge clk);
                hold_active = 1'b0;
            end
            seg_kind = $urandom_range(0, 3);
            seg_len  = (seg_kind == 3) ? $urandom_range(1, 40) : $urandom_range(1, 60);
            repeat (seg_len) begin
                case (seg_kind)
                    0:       res_ch.ready <= 1'b1;
                    1:       res_ch.ready <= 1'($urandom_range(0, 1));
                    2:       res_ch.ready <= ($urandom_range(0, 7) != 0);
                    default: res_ch.ready <= 1'b0;
                endcase
                @(posedge clk);
            end
        end
    end

    task automatic send_word(input logic [1:0] cmd, input logic draw, input logic [1:0] cls,
                             input logic [VOLUME_WIDTH-1:0] ac,
                             input logic [VOLUME_WIDTH-1:0] inlet,
                             input logic [VOLUME_WIDTH-1:0] ret);
        in_ch.valid        <= 1'b1;
        in_ch.cmd          <= cmd;
        in_ch.draw_phase   <= draw;
        in_ch.state_class  <= cls;
        in_ch.delta_ac     <= ac;
        in_ch.delta_inlet  <= inlet;
        in_ch.delta_return <= ret;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
    endtask

    task automatic idle_sender(input int cycles);
        if (cycles > 0) begin
            in_ch.valid <= 1'b0;
            repeat (cycles) @(posedge clk);
        end
    endtask

    task automatic wait_all_results();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (words_pending != 0) @(posedge clk);
    endtask

    task automatic write_cfg(input flrm_pkg::t_cfg_index idx,
                             input logic [CFG_DATA_WIDTH-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
    endtask

    task automatic load_cfg(input logic [RATIO_WIDTH-1:0] lo_ratio,
                            input logic [RATIO_WIDTH-1:0] hi_ratio,
                            input logic [FILTER_WIDTH-1:0] lo_filt,
                            input logic [FILTER_WIDTH-1:0] hi_filt,
                            input logic enable);
        write_cfg(flrm_pkg::CFG_MIN_RATIO, lo_ratio);
        write_cfg(flrm_pkg::CFG_MAX_RATIO, hi_ratio);
        write_cfg(flrm_pkg::CFG_LOW_FILTER, CFG_DATA_WIDTH'(lo_filt));
        write_cfg(flrm_pkg::CFG_HIGH_FILTER, CFG_DATA_WIDTH'(hi_filt));
        write_cfg(flrm_pkg::CFG_MON_ENABLE, CFG_DATA_WIDTH'(enable));
        cfg_we  <= 1'b0;
        cur_min = lo_ratio;
        cur_max = hi_ratio;
    endtask

    task automatic load_random_cfg();
        logic [RATIO_WIDTH-1:0]  lo_ratio;
        logic [RATIO_WIDTH-1:0]  hi_ratio;
        logic [FILTER_WIDTH-1:0] lo_filt;
        logic [FILTER_WIDTH-1:0] hi_filt;
        logic                    enable;
        case ($urandom_range(0, 3))
            0:       lo_ratio = '0;
            1:       lo_ratio = '1;
            2:       lo_ratio = RATIO_WIDTH'($urandom_range(1024, 2048));
            default: lo_ratio = RATIO_WIDTH'($urandom);
        endcase
        case ($urandom_range(0, 3))
            0:       hi_ratio = '0;
            1:       hi_ratio = '1;
            2:       hi_ratio = RATIO_WIDTH'($urandom_range(2800, 3800));
            default: hi_ratio = RATIO_WIDTH'($urandom);
        endcase
        case ($urandom_range(0, 3))
            0:       lo_filt = '0;
            1:       lo_filt = 8'd254;
            2:       lo_filt = FILTER_WIDTH'($urandom_range(1, 15));
            default: lo_filt = FILTER_WIDTH'($urandom_range(0, 254));
        endcase
        case ($urandom_range(0, 3))
            0:       hi_filt = '0;
            1:       hi_filt = 8'd254;
            2:       hi_filt = FILTER_WIDTH'($urandom_range(1, 15));
            default: hi_filt = FILTER_WIDTH'($urandom_range(0, 254));
        endcase
        enable = ($urandom_range(0, 9) != 0);
        load_cfg(lo_ratio, hi_ratio, lo_filt, hi_filt, enable);
    endtask

    // Mostly draw samples aimed near the current limits; some commands and raw noise.
    // With push set, small positive differences make both counters climb when min is all ones and max zero.
    task automatic send_random_word(input bit push);
        logic [1:0]              cmd;
        logic [1:0]              cls;
        logic                    draw;
        logic [VOLUME_WIDTH-1:0] ac;
        logic [VOLUME_WIDTH-1:0] inlet;
        logic [VOLUME_WIDTH-1:0] ret;
        logic [VOLUME_WIDTH-1:0] swap;
        logic [RATIO_WIDTH-1:0]  ratio;
        longint                  span;
        int                      pick;
        int                      jitter;
        pick  = $urandom_range(0, 99);
        cmd   = flrm_pkg::CMD_SAMPLE;
        draw  = 1'b1;
        cls   = 2'($urandom_range(0, 3));
        ac    = VOLUME_WIDTH'($urandom);
        inlet = VOLUME_WIDTH'($urandom);
        ret   = VOLUME_WIDTH'($urandom);
        if (push && pick < 95) begin
            ac    = VOLUME_WIDTH'($urandom_range(flrm_pkg::AC_MIN_DELTA + 1, 4000));
            span  = $urandom_range(1, 32'(ac));
            ret   = VOLUME_WIDTH'($urandom_range(0, 32'(VOL_TOP - span)));
            inlet = VOLUME_WIDTH'(longint'(ret) + span);
        end else if (pick < 8) begin
            cmd  = 2'($urandom_range(0, 3));
            draw = 1'($urandom_range(0, 1));
        end else if (pick < 11) begin
            cmd = flrm_pkg::CMD_STATE;
            cls = ($urandom_range(0, 2) == 0) ? flrm_pkg::CLASS_DEACTIVATE :
                                                 flrm_pkg::CLASS_ACTIVATE;
        end else if (pick < 13) begin
            cmd  = flrm_pkg::CMD_CYCLE_START;
            draw = 1'($urandom_range(0, 1));
        end else begin
            draw = ($urandom_range(0, 19) != 0);
            case ($urandom_range(0, 3))
                0:       ac = VOLUME_WIDTH'($urandom_range(0, 12));
                1:       ac = VOLUME_WIDTH'($urandom_range(flrm_pkg::AC_MIN_DELTA + 1, 4000));
                default: ac = VOLUME_WIDTH'($urandom_range(flrm_pkg::AC_MIN_DELTA + 1,
                                                           32'(VOL_TOP)));
            endcase
            case ($urandom_range(0, 2))
                0:       ratio = cur_min;
                1:       ratio = cur_max;
                default: ratio = RATIO_WIDTH'($urandom);
            endcase
            jitter = $urandom_range(0, 6);
            span   = ((longint'(ratio) * longint'(ac)) >>> 8) + jitter - 3;
            if (span < 0)
                span = 0;
            if (span > VOL_TOP)
                span = VOL_TOP;
            ret   = VOLUME_WIDTH'($urandom_range(0, 32'(VOL_TOP - span)));
            inlet = VOLUME_WIDTH'(longint'(ret) + span);
            if ($urandom_range(0, 9) == 0) begin
                swap  = inlet;
                inlet = ret;
                ret   = swap;
            end
        end
        send_word(cmd, draw, cls, ac, inlet, ret);
    endtask

    initial begin
        logic [VOLUME_WIDTH-1:0] vmax;
        int                      burst_left;
        int                      phase_words;
        bit                      push;
        vmax = '1;
        in_ch.valid        <= 1'b0;
        in_ch.cmd          <= flrm_pkg::CMD_SAMPLE;
        in_ch.draw_phase   <= 1'b0;
        in_ch.state_class  <= flrm_pkg::CLASS_NO_CHANGE;
        in_ch.delta_ac     <= '0;
        in_ch.delta_inlet  <= '0;
        in_ch.delta_return <= '0;
        cfg_we             <= 1'b0;
        cfg_index          <= flrm_pkg::CFG_MIN_RATIO;
        cfg_data           <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Default limits with monitoring disabled: samples change nothing.
        send_word(flrm_pkg::CMD_STATE, 1'b0, flrm_pkg::CLASS_ACTIVATE, '0, '0, '0);
        send_word(flrm_pkg::CMD_SAMPLE, 1'b1, flrm_pkg::CLASS_NO_CHANGE, 20'd100, '0, '0);
        send_word(CMD_RESERVED, 1'b1, CLASS_RESERVED, vmax, vmax, vmax);
        wait_all_results();

        // Zero filters: the first failing sample alarms and requests the dump.
        load_cfg(flrm_pkg::MIN_RATIO_RESET, flrm_pkg::MAX_RATIO_RESET, 8'd0, 8'd0, 1'b1);
        send_word(flrm_pkg::CMD_SAMPLE, 1'b1, flrm_pkg::CLASS_NO_CHANGE, 20'd5, '0, '0);
        send_word(flrm_pkg::CMD_SAMPLE, 1'b1, flrm_pkg::CLASS_NO_CHANGE, 20'd6, '0, '0);
        send_word(flrm_pkg::CMD_SAMPLE, 1'b1, flrm_pkg::CLASS_NO_CHANGE, 20'd6, vmax, '0);
        send_word(flrm_pkg::CMD_SAMPLE, 1'b1, flrm_pkg::CLASS_NO_CHANGE, vmax, '0, vmax);
        send_word(flrm_pkg::CMD_SAMPLE, 1'b1, flrm_pkg::CLASS_NO_CHANGE, vmax, vmax, '0);
        send_word(flrm_pkg::CMD_SAMPLE, 1'b0, flrm_pkg::CLASS_NO_CHANGE, 20'd100, '0, '0);
        // Ratios exactly on each limit pass.
        send_word(flrm_pkg::CMD_SAMPLE, 1'b1, flrm_pkg::CLASS_NO_CHANGE, 20'd256,
                  20'(flrm_pkg::MIN_RATIO_RESET), '0);
        send_word(flrm_pkg::CMD_SAMPLE, 1'b1, flrm_pkg::CLASS_NO_CHANGE, 20'd256,
                  20'(flrm_pkg::MAX_RATIO_RESET), '0);
        send_word(flrm_pkg::CMD_SAMPLE, 1'b1, flrm_pkg::CLASS_NO_CHANGE, 20'd6, '0, '0);
        send_word(flrm_pkg::CMD_CYCLE_START, 1'b0, flrm_pkg::CLASS_NO_CHANGE, '0, '0, '0);
        send_word(flrm_pkg::CMD_CYCLE_START, 1'b1, flrm_pkg::CLASS_NO_CHANGE, '0, '0, '0);
        send_word(flrm_pkg::CMD_STATE, 1'b1, flrm_pkg::CLASS_NO_CHANGE, '0, '0, '0);
        send_word(flrm_pkg::CMD_STATE, 1'b1, CLASS_RESERVED, '0, '0, '0);
        send_word(flrm_pkg::CMD_STATE, 1'b1, flrm_pkg::CLASS_DEACTIVATE, '0, '0, '0);
        send_word(flrm_pkg::CMD_SAMPLE, 1'b1, flrm_pkg::CLASS_NO_CHANGE, 20'd6, '0, '0);
        send_word(flrm_pkg::CMD_STATE, 1'b1, flrm_pkg::CLASS_ACTIVATE, '0, '0, '0);
        wait_all_results();

        // Minimum above maximum: a positive difference fails both limits at once, a zero one only the minimum.
        load_cfg('1, '0, 8'd254, 8'd254, 1'b1);
        send_word(flrm_pkg::CMD_SAMPLE, 1'b1, flrm_pkg::CLASS_NO_CHANGE, 20'd6, 20'd10, '0);
        send_word(flrm_pkg::CMD_SAMPLE, 1'b1, flrm_pkg::CLASS_NO_CHANGE, vmax, vmax, '0);
        send_word(flrm_pkg::CMD_SAMPLE, 1'b1, flrm_pkg::CLASS_NO_CHANGE, 20'd6, 20'd77,
                  20'd77);
        wait_all_results();

        load_cfg('0, '1, 8'd0, 8'd254, 1'b1);
        send_word(flrm_pkg::CMD_SAMPLE, 1'b1, flrm_pkg::CLASS_NO_CHANGE, 20'd6, 20'd2000, '0);
        send_word(flrm_pkg::CMD_SAMPLE, 1'b1, flrm_pkg::CLASS_NO_CHANGE, 20'd6, '0, '0);
        send_word(flrm_pkg::CMD_SAMPLE, 1'b1, flrm_pkg::CLASS_NO_CHANGE, 20'd6, '0, 20'd1);
        wait_all_results();

        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            push        = (phase == SATURATE_PHASE);
            phase_words = push ? SATURATE_WORDS : PHASE_WORDS;
            if (push)
                load_cfg('1, '0, 8'd254, 8'd254, 1'b1);
            else
                load_random_cfg();
            send_word(flrm_pkg::CMD_STATE, 1'b1, flrm_pkg::CLASS_ACTIVATE, '0, '0, '0);
            if (phase == HOLD_PHASE) begin
                // Keep offering words while results are held back so the block backs up.
                in_ch.valid <= 1'b0;
                hold_request = 1'b1;
                @(posedge clk);
                while (!hold_active) @(posedge clk);
                repeat (40) send_random_word(1'b0);
                wait_all_results();
            end
            burst_left = 0;
            repeat (phase_words) begin
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 40);
                    idle_sender(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12));
                end
                send_random_word(push);
                burst_left--;
            end
            wait_all_results();
        end

        repeat (10) @(posedge clk);
        if (fail_count == 0 && words_pending == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
